>>> design/twelve_hour_clock_with_alarm_defines.svh
// Assertion macros shared by the twelve-hour clock RTL.
`ifndef TWELVE_HOUR_CLOCK_WITH_ALARM_DEFINES_SVH
`define TWELVE_HOUR_CLOCK_WITH_ALARM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define THCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define THCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/thca_pkg.sv
// Types, constants and helper functions for the twelve-hour clock with alarm.
`timescale 1ns / 1ps

package thca_pkg;

    localparam int unsigned TICKS_PER_SECOND_DEF = 10;

    localparam logic [3:0] HOUR_FIRST  = 4'd1;
    localparam logic [3:0] HOUR_LAST   = 4'd12;
    localparam logic [5:0] SIXTY_LAST  = 6'd59;
    localparam logic [5:0] SNOOZE_MIN  = 6'd10;
    // minute at or above which a snooze carries into the hour (60 - 10)
    localparam logic [5:0] SNOOZE_WRAP = 6'd50;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_SET_TIME  = 2'd1,
        KIND_SET_ALARM = 2'd2,
        KIND_SNOOZE    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [3:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_hms;

    typedef struct packed {
        t_hms now;
        logic second_advanced;
        logic alarm_match;
    } t_result;

    // zero loads as one, anything above twelve loads as twelve
    function automatic logic [3:0] clamp_hour(input logic [3:0] h);
        logic [3:0] r;
        if (h < HOUR_FIRST) begin
            r = HOUR_FIRST;
        end else if (h > HOUR_LAST) begin
            r = HOUR_LAST;
        end else begin
            r = h;
        end
        return r;
    endfunction

    function automatic logic [5:0] clamp_sixty(input logic [5:0] v);
        return (v > SIXTY_LAST) ? SIXTY_LAST : v;
    endfunction

    // twelve is followed by one
    function automatic logic [3:0] next_hour(input logic [3:0] h);
        return (h >= HOUR_LAST) ? HOUR_FIRST : h + 4'd1;
    endfunction

endpackage

>>> design/thca_step.sv
// Next-state and result logic for one event of the twelve-hour clock.
`timescale 1ns / 1ps

module thca_step #(
    parameter int unsigned TICKS_PER_SECOND = thca_pkg::TICKS_PER_SECOND_DEF,
    localparam int unsigned TICK_W = $clog2(TICKS_PER_SECOND)
) (
    input  thca_pkg::t_kind   i_kind,
    input  thca_pkg::t_hms    i_load,
    input  logic [TICK_W-1:0] i_tick_count,
    input  thca_pkg::t_hms    i_clock,
    input  thca_pkg::t_hms    i_alarm,
    output logic [TICK_W-1:0] o_tick_count,
    output thca_pkg::t_hms    o_clock,
    output thca_pkg::t_hms    o_alarm,
    output thca_pkg::t_result o_result
);
    import thca_pkg::*;

    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

    logic advanced;

    // event decode and state update
    always_comb begin
        o_tick_count = i_tick_count;
        o_clock      = i_clock;
        o_alarm      = i_alarm;
        advanced     = 1'b0;
        case (i_kind)
            KIND_TICK: begin
                if (i_tick_count >= TICK_LAST) begin
                    o_tick_count = '0;
                    advanced     = 1'b1;
                    if (i_clock.seconds >= SIXTY_LAST) begin
                        o_clock.seconds = '0;
                        if (i_clock.minutes >= SIXTY_LAST) begin
                            o_clock.minutes = '0;
                            o_clock.hours   = next_hour(i_clock.hours);
                        end else begin
                            o_clock.minutes = i_clock.minutes + 6'd1;
                        end
                    end else begin
                        o_clock.seconds = i_clock.seconds + 6'd1;
                    end
                end else begin
                    o_tick_count = i_tick_count + TICK_W'(1);
                end
            end
            KIND_SET_TIME: begin
                o_clock.hours   = clamp_hour(i_load.hours);
                o_clock.minutes = clamp_sixty(i_load.minutes);
                o_clock.seconds = clamp_sixty(i_load.seconds);
            end
            KIND_SET_ALARM: begin
                o_alarm.hours   = clamp_hour(i_load.hours);
                o_alarm.minutes = clamp_sixty(i_load.minutes);
                o_alarm.seconds = clamp_sixty(i_load.seconds);
            end
            KIND_SNOOZE: begin
                // only acts while the alarm is ringing
                if (i_alarm == i_clock) begin
                    if (i_alarm.minutes >= SNOOZE_WRAP) begin
                        o_alarm.minutes = i_alarm.minutes - SNOOZE_WRAP;
                        o_alarm.hours   = next_hour(i_alarm.hours);
                    end else begin
                        o_alarm.minutes = i_alarm.minutes + SNOOZE_MIN;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result reflects the state after the event
    always_comb begin
        o_result.now             = o_clock;
        o_result.second_advanced = advanced;
        o_result.alarm_match     = (o_alarm == o_clock);
    end

endmodule

>>> design/twelve_hour_clock_with_alarm.sv
// Top level of the twelve-hour real-time clock with alarm and snooze.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event per beat:
//   i_kind selects tick, set time, set alarm or snooze; the hour, minute and
//   second fields are used only by the two set events and are clamped.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   beat per event: the time after the event, whether a tick rolled the
//   seconds, and whether the alarm equals the time.
// Timing:
//   The result of an accepted event is registered in the output register, or
//   in the skid register while the output register still holds a result.
//   Throughput is one event per cycle while o_in_ready is high; between the
//   state registers and the output register lies the single update stage.
// Stalls:
//   A two-entry output buffer (output register plus skid register) lets one
//   more event be taken while a result waits; o_in_ready drops only when
//   both entries are full.
// Reset:
//   i_rst_n low for one edge sets the time and alarm to 12:00:00, clears
//   the tick count and empties the output buffer.
`timescale 1ns / 1ps

module twelve_hour_clock_with_alarm #(
    parameter int unsigned TICKS_PER_SECOND = thca_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_hour_value,
    input  logic [5:0] i_minute_value,
    input  logic [5:0] i_second_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_now_hours,
    output logic [5:0] o_now_minutes,
    output logic [5:0] o_now_seconds,
    output logic       o_second_advanced,
    output logic       o_alarm_match
);
    import thca_pkg::*;

    `include "twelve_hour_clock_with_alarm_defines.svh"

    localparam int unsigned TICK_W = $clog2(TICKS_PER_SECOND);

    logic [TICK_W-1:0] r_tick;
    t_hms              r_clock;
    t_hms              r_alarm;
    logic [TICK_W-1:0] n_tick;
    t_hms              n_clock;
    t_hms              n_alarm;
    t_hms              load;
    t_result           step_result;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    logic in_beat;
    logic out_beat;

    assign o_in_ready = !r_skid_valid;
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_beat   = r_out_valid && i_out_ready;

    assign load.hours   = i_hour_value;
    assign load.minutes = i_minute_value;
    assign load.seconds = i_second_value;

    thca_step #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_step (
        .i_kind      (t_kind'(i_kind)),
        .i_load      (load),
        .i_tick_count(r_tick),
        .i_clock     (r_clock),
        .i_alarm     (r_alarm),
        .o_tick_count(n_tick),
        .o_clock     (n_clock),
        .o_alarm     (n_alarm),
        .o_result    (step_result)
    );

    // clock and alarm state, updated on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_clock <= '{hours: HOUR_LAST, minutes: 6'd0, seconds: 6'd0};
            r_alarm <= '{hours: HOUR_LAST, minutes: 6'd0, seconds: 6'd0};
        end else if (in_beat) begin
            r_tick  <= n_tick;
            r_clock <= n_clock;
            r_alarm <= n_alarm;
        end
    end

    // output buffer valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_beat) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_beat;
            end
        end else if (in_beat) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (out_beat) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_beat) begin
                r_out <= step_result;
            end
        end else if (in_beat) begin
            if (r_out_valid) begin
                r_skid <= step_result;
            end else begin
                r_out <= step_result;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_now_hours       = r_out.now.hours;
    assign o_now_minutes     = r_out.now.minutes;
    assign o_now_seconds     = r_out.now.seconds;
    assign o_second_advanced = r_out.second_advanced;
    assign o_alarm_match     = r_out.alarm_match;

    // checks
    `THCA_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    `THCA_ASSERT_IMP(a_hour_range, i_clk, i_rst_n, 1'b1, (r_clock.hours >= HOUR_FIRST) && (r_clock.hours <= HOUR_LAST) && (r_alarm.hours >= HOUR_FIRST) && (r_alarm.hours <= HOUR_LAST), "hour out of range")
    `THCA_ASSERT_IMP(a_min_sec_range, i_clk, i_rst_n, 1'b1, (r_clock.minutes <= SIXTY_LAST) && (r_clock.seconds <= SIXTY_LAST) && (r_alarm.minutes <= SIXTY_LAST) && (r_alarm.seconds <= SIXTY_LAST), "minute or second out of range")
    `THCA_ASSERT_IMP(a_tick_range, i_clk, i_rst_n, 1'b1, r_tick <= TICK_W'(TICKS_PER_SECOND - 1), "tick count past period")
    `THCA_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, in_beat, r_out_valid, "accepted beat left no result")

endmodule
